// ===== rtl/asp_pkg.sv =====
// Shared types, register indexes, field widths and reset values for the
// ADC average to motor/servo setpoint block. No dependencies.
package asp_pkg;

   localparam int DEF_WINDOW_DEPTH = 10;
   localparam int DEF_SAMPLE_BITS  = 10;

   // configuration port
   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W  = 16;

   // register and result field widths
   localparam int FULL_SCALE_W = 10;
   localparam int SPAN_W       = 8;
   localparam int OFFSET_W     = 7;
   localparam int COUNT_W      = 16;
   localparam int ABS_W        = 8;
   localparam int SET_W        = 8;
   localparam int PULSE_W      = 16;
   localparam int RSP_DATA_W   = 72;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_ADC_FULL_SCALE  = 4'd0,
      REG_SPEED_SPAN      = 4'd1,
      REG_SPEED_OFFSET    = 4'd2,
      REG_ANGLE_SPAN      = 4'd3,
      REG_ANGLE_OFFSET    = 4'd4,
      REG_MOTOR_PERIOD    = 4'd5,
      REG_SERVO_MAX_COUNT = 4'd6,
      REG_SERVO_MIN_COUNT = 4'd7
   } reg_index_type;

   localparam logic [FULL_SCALE_W-1:0] RST_ADC_FULL_SCALE  = 10'd1023;
   localparam logic [SPAN_W-1:0]       RST_SPEED_SPAN      = 8'd198;
   localparam logic [OFFSET_W-1:0]     RST_SPEED_OFFSET    = 7'd99;
   localparam logic [SPAN_W-1:0]       RST_ANGLE_SPAN      = 8'd180;
   localparam logic [OFFSET_W-1:0]     RST_ANGLE_OFFSET    = 7'd90;
   localparam logic [COUNT_W-1:0]      RST_MOTOR_PERIOD    = 16'd1999;
   localparam logic [COUNT_W-1:0]      RST_SERVO_MAX_COUNT = 16'd2999;
   localparam logic [COUNT_W-1:0]      RST_SERVO_MIN_COUNT = 16'd749;

   typedef struct packed {
      logic [FULL_SCALE_W-1:0] adc_full_scale;
      logic [SPAN_W-1:0]       speed_span;
      logic [OFFSET_W-1:0]     speed_offset;
      logic [SPAN_W-1:0]       angle_span;
      logic [OFFSET_W-1:0]     angle_offset;
      logic [COUNT_W-1:0]      motor_period;
      logic [COUNT_W-1:0]      servo_max_count;
      logic [COUNT_W-1:0]      servo_min_count;
   } cfg_type;

   typedef enum logic [1:0] {
      DIR_STOP    = 2'd0,
      DIR_FORWARD = 2'd1,
      DIR_REVERSE = 2'd2
   } direction_type;

   // last member sits in the lowest bits
   typedef struct packed {
      logic [PULSE_W-1:0]       servo_pulse;
      logic [PULSE_W-1:0]       motor_pulse;
      direction_type            direction;
      logic signed [SET_W-1:0]  angle_setting;
      logic signed [SET_W-1:0]  speed_setting;
      logic [ABS_W-1:0]         abs_angle;
      logic [ABS_W-1:0]         abs_speed;
   } result_type;

   typedef struct packed {
      logic done;
      logic [ABS_W-1:0] abs_value;
   } lane_status_type;

   typedef enum logic [2:0] {
      LANE_IDLE,
      LANE_AVG,
      LANE_MUL,
      LANE_SCALE_GO,
      LANE_SCALE_WAIT
   } lane_state_type;

   typedef enum logic [1:0] {
      TOP_IDLE,
      TOP_LANES,
      TOP_MERGE,
      TOP_HOLD
   } top_state_type;

   // zero full scale divides by one
   function automatic logic [FULL_SCALE_W-1:0] nz_scale(input logic [FULL_SCALE_W-1:0] d);
      nz_scale = (d == '0) ? FULL_SCALE_W'(1) : d;
   endfunction

endpackage

// ===== rtl/asp_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
// Standalone; used by the lanes and by the merge stage.
module asp_div #(
   parameter int DIVIDEND_W = 18,
   parameter int DIVISOR_W  = 10
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DIVIDEND_W-1:0] dividend,
   input  logic [DIVISOR_W-1:0]  divisor,
   output logic                  done,
   output logic [DIVIDEND_W-1:0] quotient
);
   localparam int CNT_W = $clog2(DIVIDEND_W + 1);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [DIVISOR_W-1:0]  div_ff, div_in;
   logic [DIVISOR_W:0]    rem_shift;
   logic [DIVISOR_W:0]    rem_diff;
   logic                  fits;

   always_comb begin
      rem_shift = {rem_ff, quo_ff[DIVIDEND_W-1]};
      rem_diff  = rem_shift - {1'b0, div_ff};
      fits      = rem_shift >= {1'b0, div_ff};
      busy_in   = busy_ff;
      done_in   = 1'b0;
      cnt_in    = cnt_ff;
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      div_in    = div_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(DIVIDEND_W);
         rem_in  = '0;
         quo_in  = dividend;
         div_in  = divisor;
      end else if (busy_ff) begin
         rem_in = fits ? rem_diff[DIVISOR_W-1:0] : rem_shift[DIVISOR_W-1:0];
         quo_in = {quo_ff[DIVIDEND_W-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      div_ff <= div_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ===== rtl/asp_lane.sv =====
// One channel lane: sample ring, running sum, window average and scaling
// to an absolute value. Uses asp_pkg and asp_div.
module asp_lane #(
   parameter int WINDOW_DEPTH = asp_pkg::DEF_WINDOW_DEPTH,
   parameter int SAMPLE_BITS  = asp_pkg::DEF_SAMPLE_BITS
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic [SAMPLE_BITS-1:0]               sample,
   input  logic [asp_pkg::SPAN_W-1:0]           span,
   input  logic [asp_pkg::FULL_SCALE_W-1:0]     full_scale,
   output asp_pkg::lane_status_type             status
);
   localparam int SLOT_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
   localparam int SUM_W  = $clog2(WINDOW_DEPTH * ((1 << SAMPLE_BITS) - 1) + 1);
   localparam int PROD_W = SAMPLE_BITS + asp_pkg::SPAN_W;
   localparam int DIVR_W = asp_pkg::FULL_SCALE_W;
   // average by reciprocal multiply; exact for every sum below 2**SUM_W
   localparam int AVG_SHIFT  = SUM_W + $clog2(WINDOW_DEPTH);
   localparam int RECIP_W    = AVG_SHIFT + 1;
   localparam int AVG_PROD_W = SUM_W + RECIP_W;
   localparam logic [RECIP_W-1:0] AVG_RECIP =
      RECIP_W'(((longint'(1) << AVG_SHIFT) + WINDOW_DEPTH - 1) / WINDOW_DEPTH);
   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW_DEPTH - 1);

   asp_pkg::lane_state_type state_ff, state_in;

   logic [SAMPLE_BITS-1:0] window_ff [WINDOW_DEPTH];
   logic [SLOT_W-1:0]      slot_ff, slot_in;
   logic [SUM_W-1:0]       sum_ff, sum_in;
   logic [SAMPLE_BITS-1:0] avg_ff, avg_in;
   logic [AVG_PROD_W-1:0]  avg_prod;
   logic [PROD_W-1:0]      prod_ff, prod_in;
   logic [SAMPLE_BITS-1:0] old_sample;
   logic                   take;

   logic                   div_start;
   logic [PROD_W-1:0]      div_dividend;
   logic [DIVR_W-1:0]      div_divisor;
   logic                   div_done;
   logic [PROD_W-1:0]      div_quotient;

   asp_div #(
      .DIVIDEND_W (PROD_W),
      .DIVISOR_W  (DIVR_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quotient)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         asp_pkg::LANE_IDLE:       if (start) state_in = asp_pkg::LANE_AVG;
         asp_pkg::LANE_AVG:        state_in = asp_pkg::LANE_MUL;
         asp_pkg::LANE_MUL:        state_in = asp_pkg::LANE_SCALE_GO;
         asp_pkg::LANE_SCALE_GO:   state_in = asp_pkg::LANE_SCALE_WAIT;
         asp_pkg::LANE_SCALE_WAIT: if (div_done) state_in = asp_pkg::LANE_IDLE;
         default:                  state_in = asp_pkg::LANE_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      take         = 1'b0;
      div_start    = 1'b0;
      div_dividend = prod_ff;
      div_divisor  = asp_pkg::nz_scale(full_scale);
      status.done  = 1'b0;
      case (state_ff)
         asp_pkg::LANE_IDLE:       take = start;
         asp_pkg::LANE_SCALE_GO:   div_start = 1'b1;
         asp_pkg::LANE_SCALE_WAIT: status.done = div_done;
         default:                  take = 1'b0;
      endcase
      // saturate to the absolute range
      if (div_quotient[PROD_W-1:asp_pkg::ABS_W] != '0) begin
         status.abs_value = '1;
      end else begin
         status.abs_value = div_quotient[asp_pkg::ABS_W-1:0];
      end
   end

   always_comb begin
      old_sample = window_ff[slot_ff];
      sum_in     = sum_ff + SUM_W'(sample) - SUM_W'(old_sample);
      slot_in    = (slot_ff == LAST_SLOT) ? '0 : slot_ff + 1'b1;
      avg_prod   = AVG_PROD_W'(sum_ff) * AVG_PROD_W'(AVG_RECIP);
      avg_in     = avg_prod[AVG_SHIFT +: SAMPLE_BITS];
      prod_in    = PROD_W'(avg_ff) * PROD_W'(span);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= asp_pkg::LANE_IDLE;
         slot_ff  <= '0;
         sum_ff   <= '0;
         for (int i = 0; i < WINDOW_DEPTH; i++) window_ff[i] <= '0;
      end else begin
         state_ff <= state_in;
         if (take) begin
            window_ff[slot_ff] <= sample;
            slot_ff            <= slot_in;
            sum_ff             <= sum_in;
         end
      end
      if (state_ff == asp_pkg::LANE_AVG) avg_ff <= avg_in;
      if (state_ff == asp_pkg::LANE_MUL) prod_ff <= prod_in;
   end

endmodule

// ===== rtl/asp_merge.sv =====
// Merge stage: signed settings, direction, motor and servo pulse widths
// from the two lane absolute values. Uses asp_pkg and two asp_div units.
module asp_merge (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [asp_pkg::ABS_W-1:0]    abs_speed,
   input  logic [asp_pkg::ABS_W-1:0]    abs_angle,
   input  asp_pkg::cfg_type             cfg,
   output logic                         done,
   output asp_pkg::result_type          result
);
   localparam int PROD_W = 24;
   localparam int DIVR_W = 8;
   localparam int DIFF_W = 10;
   localparam int SERVO_W = PROD_W + 2;

   logic                           go_ff, div_go_ff, done_ff;
   logic [asp_pkg::ABS_W-1:0]      abs_s_ff, abs_a_ff;
   logic [PROD_W-1:0]              motor_prod_ff, motor_prod_in;
   logic [PROD_W-1:0]              servo_prod_ff, servo_prod_in;
   logic                           span_neg_ff;
   asp_pkg::result_type            result_ff, result_in;

   logic signed [DIFF_W-1:0]       diff_s, diff_a;
   logic signed [asp_pkg::SET_W-1:0] set_s, set_a;
   logic [asp_pkg::SET_W-1:0]      mag_s;
   logic [asp_pkg::COUNT_W:0]      span;
   logic [asp_pkg::COUNT_W-1:0]    span_mag;
   logic [DIVR_W-1:0]              motor_div, servo_div;
   logic                           motor_done, servo_done;
   logic [PROD_W-1:0]              motor_q, servo_q;
   logic signed [SERVO_W-1:0]      servo_signed, servo_sum;

   asp_div #(.DIVIDEND_W(PROD_W), .DIVISOR_W(DIVR_W)) u_motor_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_go_ff),
      .dividend (motor_prod_ff),
      .divisor  (motor_div),
      .done     (motor_done),
      .quotient (motor_q)
   );

   asp_div #(.DIVIDEND_W(PROD_W), .DIVISOR_W(DIVR_W)) u_servo_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_go_ff),
      .dividend (servo_prod_ff),
      .divisor  (servo_div),
      .done     (servo_done),
      .quotient (servo_q)
   );

   always_comb begin
      diff_s = signed'(DIFF_W'(abs_s_ff)) - signed'(DIFF_W'(cfg.speed_offset));
      diff_a = signed'(DIFF_W'(abs_a_ff)) - signed'(DIFF_W'(cfg.angle_offset));
      // offsets never exceed 127, so only the upper bound can be crossed
      set_s  = (diff_s > DIFF_W'(127)) ? 8'sd127 : diff_s[asp_pkg::SET_W-1:0];
      set_a  = (diff_a > DIFF_W'(127)) ? 8'sd127 : diff_a[asp_pkg::SET_W-1:0];
      mag_s  = set_s[asp_pkg::SET_W-1] ? asp_pkg::SET_W'(-set_s) : asp_pkg::SET_W'(set_s);

      span     = {1'b0, cfg.servo_max_count} - {1'b0, cfg.servo_min_count};
      span_mag = span[asp_pkg::COUNT_W] ? asp_pkg::COUNT_W'(-span)
                                        : span[asp_pkg::COUNT_W-1:0];

      motor_prod_in = PROD_W'(cfg.motor_period) * PROD_W'(mag_s);
      servo_prod_in = PROD_W'(abs_a_ff) * PROD_W'(span_mag);

      motor_div = (cfg.speed_offset == '0) ? DIVR_W'(1) : DIVR_W'(cfg.speed_offset);
      servo_div = (cfg.angle_span == '0) ? DIVR_W'(1) : cfg.angle_span;

      // quotient truncates toward zero, so negate the magnitude afterwards
      servo_signed = span_neg_ff ? -signed'(SERVO_W'(servo_q)) : signed'(SERVO_W'(servo_q));
      servo_sum    = servo_signed + signed'(SERVO_W'(cfg.servo_min_count));

      result_in.abs_speed     = abs_s_ff;
      result_in.abs_angle     = abs_a_ff;
      result_in.speed_setting = set_s;
      result_in.angle_setting = set_a;
      if (set_s == '0) begin
         result_in.direction = asp_pkg::DIR_STOP;
      end else if (set_s[asp_pkg::SET_W-1]) begin
         result_in.direction = asp_pkg::DIR_REVERSE;
      end else begin
         result_in.direction = asp_pkg::DIR_FORWARD;
      end
      result_in.motor_pulse = (motor_q[PROD_W-1:asp_pkg::PULSE_W] != '0) ? '1
                              : motor_q[asp_pkg::PULSE_W-1:0];
      if (servo_sum[SERVO_W-1]) begin
         result_in.servo_pulse = '0;
      end else if (servo_sum[SERVO_W-2:asp_pkg::PULSE_W] != '0) begin
         result_in.servo_pulse = '1;
      end else begin
         result_in.servo_pulse = servo_sum[asp_pkg::PULSE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         go_ff     <= 1'b0;
         div_go_ff <= 1'b0;
         done_ff   <= 1'b0;
      end else begin
         go_ff     <= start;
         div_go_ff <= go_ff;
         done_ff   <= motor_done;
      end
      if (start) begin
         abs_s_ff <= abs_speed;
         abs_a_ff <= abs_angle;
      end
      if (go_ff) begin
         motor_prod_ff <= motor_prod_in;
         servo_prod_ff <= servo_prod_in;
         span_neg_ff   <= span[asp_pkg::COUNT_W];
      end
      if (motor_done) result_ff <= result_in;
   end

   assign done   = done_ff;
   assign result = result_ff;

   assert property (@(posedge clock) disable iff (reset) motor_done == servo_done)
      else $error("motor and servo dividers out of step");

endmodule

// ===== rtl/adc_average_motor_servo_setpoint.sv =====
// Top level: configuration registers, sequencing of the two lanes and the
// merge stage, and the result register. Uses asp_pkg, asp_lane, asp_merge.
//
// Usage:
//   req_ channel carries one word per ADC sample pair (speed, angle). Each
//   word goes into both lanes, which run side by side: ring update, window
//   average by a reciprocal multiply, then scaling by an iterative divider
//   in each lane. The merge stage then derives the signed settings, the
//   bridge direction and the two pulse widths with two more dividers working
//   in parallel.
//   One word is in flight at a time, so a new word is accepted only after
//   the previous one has been through the lanes and the merge stage. The
//   dividers produce one quotient bit per cycle, SAMPLE_BITS+8 bits in the
//   lanes and 24 bits in the merge stage.
//   rsp_ holds the result in an output register until taken. A new req_ word
//   is taken while an earlier result still waits; if that result is still
//   not taken when the next one is done, the block holds and stops taking.
//   csr_ writes are always accepted and must happen only while idle.
//   Reset clears the sample rings, sums and write slot and restores the
//   register defaults; no result is pending after reset.
module adc_average_motor_servo_setpoint #(
   parameter int WINDOW_DEPTH = asp_pkg::DEF_WINDOW_DEPTH,
   parameter int SAMPLE_BITS  = asp_pkg::DEF_SAMPLE_BITS
) (
   input  logic                                clock,
   input  logic                                reset,
   // req_tdata: speed_sample, angle_sample (from bit 0 up)
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0]  req_tdata,
   // rsp_tdata: abs_speed, abs_angle, speed_setting, angle_setting,
   //            direction, motor_pulse, servo_pulse (from bit 0 up)
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [asp_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [asp_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [asp_pkg::CSR_DATA_W-1:0]      csr_data
);
   localparam int RESULT_W = $bits(asp_pkg::result_type);

   asp_pkg::top_state_type   state_ff, state_in;
   asp_pkg::cfg_type         cfg_ff;
   asp_pkg::result_type      rsp_ff;
   asp_pkg::result_type      merge_result;
   asp_pkg::lane_status_type speed_status, angle_status;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     req_take, merge_start, merge_done, out_free, out_load;

   asp_lane #(.WINDOW_DEPTH(WINDOW_DEPTH), .SAMPLE_BITS(SAMPLE_BITS)) u_speed_lane (
      .clock      (clock),
      .reset      (reset),
      .start      (req_take),
      .sample     (req_tdata[SAMPLE_BITS-1:0]),
      .span       (cfg_ff.speed_span),
      .full_scale (cfg_ff.adc_full_scale),
      .status     (speed_status)
   );

   asp_lane #(.WINDOW_DEPTH(WINDOW_DEPTH), .SAMPLE_BITS(SAMPLE_BITS)) u_angle_lane (
      .clock      (clock),
      .reset      (reset),
      .start      (req_take),
      .sample     (req_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]),
      .span       (cfg_ff.angle_span),
      .full_scale (cfg_ff.adc_full_scale),
      .status     (angle_status)
   );

   asp_merge u_merge (
      .clock     (clock),
      .reset     (reset),
      .start     (merge_start),
      .abs_speed (speed_status.abs_value),
      .abs_angle (angle_status.abs_value),
      .cfg       (cfg_ff),
      .done      (merge_done),
      .result    (merge_result)
   );

   assign out_free = !rsp_valid_ff || rsp_tready;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         asp_pkg::TOP_IDLE:  if (req_tvalid) state_in = asp_pkg::TOP_LANES;
         asp_pkg::TOP_LANES: if (speed_status.done) state_in = asp_pkg::TOP_MERGE;
         asp_pkg::TOP_MERGE: begin
            if (merge_done) state_in = out_free ? asp_pkg::TOP_IDLE : asp_pkg::TOP_HOLD;
         end
         asp_pkg::TOP_HOLD:  if (out_free) state_in = asp_pkg::TOP_IDLE;
         default:            state_in = asp_pkg::TOP_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_tready  = 1'b0;
      merge_start = 1'b0;
      out_load    = 1'b0;
      case (state_ff)
         asp_pkg::TOP_IDLE:  req_tready = 1'b1;
         asp_pkg::TOP_LANES: merge_start = speed_status.done;
         asp_pkg::TOP_MERGE: out_load = merge_done && out_free;
         asp_pkg::TOP_HOLD:  out_load = out_free;
         default:            req_tready = 1'b0;
      endcase
      req_take     = req_tvalid && req_tready;
      rsp_valid_in = out_load || (rsp_valid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= asp_pkg::TOP_IDLE;
         rsp_valid_ff <= 1'b0;
         cfg_ff.adc_full_scale  <= asp_pkg::RST_ADC_FULL_SCALE;
         cfg_ff.speed_span      <= asp_pkg::RST_SPEED_SPAN;
         cfg_ff.speed_offset    <= asp_pkg::RST_SPEED_OFFSET;
         cfg_ff.angle_span      <= asp_pkg::RST_ANGLE_SPAN;
         cfg_ff.angle_offset    <= asp_pkg::RST_ANGLE_OFFSET;
         cfg_ff.motor_period    <= asp_pkg::RST_MOTOR_PERIOD;
         cfg_ff.servo_max_count <= asp_pkg::RST_SERVO_MAX_COUNT;
         cfg_ff.servo_min_count <= asp_pkg::RST_SERVO_MIN_COUNT;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid) begin
            // truncate each word to its register width; drop unknown indexes
            case (csr_index)
               asp_pkg::REG_ADC_FULL_SCALE:
                  cfg_ff.adc_full_scale <= csr_data[asp_pkg::FULL_SCALE_W-1:0];
               asp_pkg::REG_SPEED_SPAN:
                  cfg_ff.speed_span <= csr_data[asp_pkg::SPAN_W-1:0];
               asp_pkg::REG_SPEED_OFFSET:
                  cfg_ff.speed_offset <= csr_data[asp_pkg::OFFSET_W-1:0];
               asp_pkg::REG_ANGLE_SPAN:
                  cfg_ff.angle_span <= csr_data[asp_pkg::SPAN_W-1:0];
               asp_pkg::REG_ANGLE_OFFSET:
                  cfg_ff.angle_offset <= csr_data[asp_pkg::OFFSET_W-1:0];
               asp_pkg::REG_MOTOR_PERIOD:    cfg_ff.motor_period <= csr_data;
               asp_pkg::REG_SERVO_MAX_COUNT: cfg_ff.servo_max_count <= csr_data;
               asp_pkg::REG_SERVO_MIN_COUNT: cfg_ff.servo_min_count <= csr_data;
               default: ;
            endcase
         end
      end
      if (out_load) rsp_ff <= merge_result;
   end

   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(asp_pkg::RSP_DATA_W - RESULT_W)'(0), rsp_ff};

   assert property (@(posedge clock) disable iff (reset)
      speed_status.done == angle_status.done)
      else $error("lanes finished in different cycles");

   assert property (@(posedge clock) disable iff (reset)
      speed_status.done |-> state_ff == asp_pkg::TOP_LANES)
      else $error("lane finished outside the lane phase");

   assert property (@(posedge clock) disable iff (reset)
      merge_done |-> state_ff == asp_pkg::TOP_MERGE)
      else $error("merge finished outside the merge phase");

   assert property (@(posedge clock) disable iff (reset)
      state_ff == asp_pkg::TOP_HOLD |-> rsp_valid_ff)
      else $error("holding a result with an empty output register");

endmodule
